[design/dsmp_pkg.sv]
// ----------------------------------------------------------------------------
// dsmp_pkg
// Shared constants for the distinct sum / modular product block: field
// widths, table depth, segment layout of the cell row and the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

package dsmp_pkg;

    localparam int TABLE_DEPTH = 1024;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 42;
    localparam int PROD_W   = 31;
    localparam int DCOUNT_W = 11;

    // entry count must hold TABLE_DEPTH itself
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    // cells are grouped into segments whose hits are reduced per cycle
    localparam int SEG_CELLS = 32;
    localparam int NUM_SEG   = (TABLE_DEPTH + SEG_CELLS - 1) / SEG_CELLS;

    // modulus and the magnitude width of a reduced product
    localparam logic [31:0] PROD_MOD  = 32'd1000000007;
    localparam logic [31:0] PROD_MOD2 = 32'd2000000014;
    localparam int MAG_W  = 30;

    // full product of two reduced magnitudes, quotient estimate widths
    localparam int X_W   = 2 * MAG_W;
    localparam int QUO_W = MAG_W + 1;
    localparam int QMU_W = 2 * QUO_W;

    // floor(2^(2*MAG_W) / PROD_MOD)
    localparam logic [QUO_W-1:0] RECIP_MU = 31'd1152921496;

endpackage

`default_nettype wire

[design/dsmp_cell.sv]
// ----------------------------------------------------------------------------
// dsmp_cell
// One table entry: holds a value, takes its left neighbor's value on an
// insert shift and registers whether it matches the probe.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmp_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_shift,
    input  wire logic signed [dsmp_pkg::SAMPLE_W-1:0] i_prev,
    input  wire logic signed [dsmp_pkg::SAMPLE_W-1:0] i_probe,
    input  wire logic                                i_live,
    output logic signed [dsmp_pkg::SAMPLE_W-1:0]      o_value,
    output logic                                     o_hit
);
    import dsmp_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_hit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_prev;
        end
    end

    // only entries below the fill count take part in the compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_live && (r_value == i_probe);
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

[design/dsmp_row.sv]
// ----------------------------------------------------------------------------
// dsmp_row
// Row of table cells. Insert shifts every entry one cell down and puts the
// probe in cell 0; hits are reduced per segment and registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmp_row (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_shift,
    input  wire logic signed [dsmp_pkg::SAMPLE_W-1:0] i_probe,
    input  wire logic [dsmp_pkg::COUNT_W-1:0]         i_count,
    output logic                                     o_found
);
    import dsmp_pkg::*;

    logic signed [SAMPLE_W-1:0] w_value [TABLE_DEPTH];
    logic [NUM_SEG*SEG_CELLS-1:0] w_hit;
    logic [NUM_SEG-1:0]           r_seg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic signed [SAMPLE_W-1:0] w_prev;
            logic                       w_live;

            if (gi == 0) begin : g_head
                assign w_prev = i_probe;
            end else begin : g_body
                assign w_prev = w_value[gi-1];
            end

            assign w_live = (COUNT_W'(gi) < i_count);

            dsmp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_prev  (w_prev),
                .i_probe (i_probe),
                .i_live  (w_live),
                .o_value (w_value[gi]),
                .o_hit   (w_hit[gi])
            );
        end

        // pad a partial last segment
        if (NUM_SEG * SEG_CELLS > TABLE_DEPTH) begin : g_pad
            assign w_hit[NUM_SEG*SEG_CELLS-1:TABLE_DEPTH] = '0;
        end

        for (gi = 0; gi < NUM_SEG; gi++) begin : g_seg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_seg[gi] <= 1'b0;
                end else begin
                    r_seg[gi] <= |w_hit[gi*SEG_CELLS +: SEG_CELLS];
                end
            end
        end
    endgenerate

    assign o_found = |r_seg;

endmodule

`default_nettype wire

[design/dsmp_modmul.sv]
// ----------------------------------------------------------------------------
// dsmp_modmul
// Modular multiplier: (a * b) mod PROD_MOD on magnitudes. One full product,
// a reciprocal estimate of the quotient and a final correction; o_done
// pulses when the corrected result is registered on o_res.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmp_modmul (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [dsmp_pkg::MAG_W-1:0]       i_a,
    input  wire logic [dsmp_pkg::SAMPLE_W-1:0]    i_b,
    output logic                                  o_done,
    output logic [dsmp_pkg::MAG_W-1:0]            o_res
);
    import dsmp_pkg::*;

    logic [4:0]          r_stage;
    logic                r_done;
    logic [MAG_W-1:0]    r_a;
    logic [MAG_W-1:0]    r_b;
    logic [X_W-1:0]      r_x;
    logic [QUO_W-1:0]    r_q;
    logic [31:0]         r_qp;
    logic [31:0]         r_rem;
    logic [MAG_W-1:0]    r_res;

    logic [SAMPLE_W-1:0] w_b1;
    logic [SAMPLE_W-1:0] w_b2;
    logic [QMU_W-1:0]    w_qmu;
    logic [31:0]         w_qp;
    logic [31:0]         w_r1;
    logic [31:0]         w_r2;

    // b is below 3*PROD_MOD, so two subtractions bring it into range
    always_comb begin
        w_b1  = (i_b >= PROD_MOD) ? (i_b - PROD_MOD) : i_b;
        w_b2  = (w_b1 >= PROD_MOD) ? (w_b1 - PROD_MOD) : w_b1;
        w_qmu = QMU_W'(r_x[X_W-1:MAG_W-1]) * QMU_W'(RECIP_MU);
        w_qp  = 32'(r_q) * PROD_MOD;
        w_r1  = r_rem - PROD_MOD;
        w_r2  = r_rem - PROD_MOD2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[3:0], i_start};
            r_done  <= r_stage[4];
        end
    end

    // quotient estimate is at most two low, so the remainder is below 3*PROD_MOD
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= w_b2[MAG_W-1:0];
        end
        r_x   <= X_W'(r_a) * X_W'(r_b);
        r_q   <= w_qmu[QMU_W-1:MAG_W+1];
        r_qp  <= w_qp;
        r_rem <= r_x[31:0] - r_qp;
        if (r_rem >= PROD_MOD2) begin
            r_res <= w_r2[MAG_W-1:0];
        end else if (r_rem >= PROD_MOD) begin
            r_res <= w_r1[MAG_W-1:0];
        end else begin
            r_res <= r_rem[MAG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

[design/distinct_sum_mod_product.sv]
// ----------------------------------------------------------------------------
// distinct_sum_mod_product
// Keeps the set of distinct signed samples with their sum and their
// product modulo 1000000007 (truncating remainder, sign kept).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries i_sample and i_restart;
//   each accepted item yields exactly one result item on o_out_valid /
//   i_out_ready. Restart empties the set before the sample is handled.
//   The block works on one item at a time; o_in_ready is high when idle.
//   A duplicate or a dropped value (full table) passes the compare,
//   segment, decision and output states; a new value also waits in the
//   multiply state for the modular multiply (full product, reciprocal
//   quotient estimate, final correction). The next item is taken only once
//   the block is back in idle, after the result register has been loaded.
//   The membership test compares all cells at once, then reduces hits in
//   32-cell segments over two registered stages.
//   A result sits in the output register until taken; a stalled receiver
//   holds the next item in its final state until the register frees up.
//   Reset empties the set (count 0, sum 0, product 1); table contents are
//   left as they are and are never compared before being written, so no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_sum_mod_product (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [dsmp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_restart,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_was_duplicate,
    output logic                                     o_set_overflow,
    output logic [dsmp_pkg::DCOUNT_W-1:0]             o_distinct_count,
    output logic signed [dsmp_pkg::SUM_W-1:0]         o_running_sum,
    output logic signed [dsmp_pkg::PROD_W-1:0]        o_running_product
);
    import dsmp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_SEG  = 6'b000100,
        S_DEC  = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic [COUNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_dup;
    logic                       r_ovf;
    logic                       r_neg;

    logic                       w_accept;
    logic                       w_found;
    logic                       w_insert;
    logic                       w_mul_done;
    logic [MAG_W-1:0]           w_mul_res;
    logic [SAMPLE_W-1:0]        w_sample_abs;
    logic [PROD_W-1:0]          w_prod_abs;
    logic [PROD_W-1:0]          w_res_mag;
    logic                       w_out_free;
    logic [31:0]                w_count_ext;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !o_out_valid || i_out_ready;

    // insert when the value is new and the table has room
    assign w_insert = (r_state == S_DEC) && !w_found
                      && (r_count != COUNT_W'(TABLE_DEPTH));

    assign w_sample_abs = r_sample[SAMPLE_W-1] ? (~r_sample + 1'b1) : r_sample;
    assign w_prod_abs   = r_prod[PROD_W-1] ? (~r_prod + 1'b1) : r_prod;
    assign w_res_mag    = {1'b0, w_mul_res};
    assign w_count_ext  = 32'(r_count);

    dsmp_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_insert),
        .i_probe (r_sample),
        .i_count (r_count),
        .o_found (w_found)
    );

    dsmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_insert),
        .i_a     (w_prod_abs[MAG_W-1:0]),
        .i_b     (w_sample_abs),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_SEG;
            S_SEG: n_state = S_DEC;
            S_DEC: begin
                n_state = w_insert ? S_MUL : S_OUT;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_prod      <= PROD_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // clear the set before the restart item is looked up
            if (w_accept && i_restart) begin
                r_count <= '0;
                r_sum   <= '0;
                r_prod  <= PROD_W'(1);
            end

            if (w_insert) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(r_sample);
            end

            if ((r_state == S_MUL) && w_mul_done) begin
                r_prod <= r_neg ? (~w_res_mag + 1'b1) : w_res_mag;
            end

            if ((r_state == S_OUT) && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
        if (r_state == S_DEC) begin
            r_dup <= w_found;
            r_ovf <= !w_found && (r_count == COUNT_W'(TABLE_DEPTH));
            r_neg <= r_prod[PROD_W-1] ^ r_sample[SAMPLE_W-1];
        end
        if ((r_state == S_OUT) && w_out_free) begin
            o_was_duplicate   <= r_dup;
            o_set_overflow    <= r_ovf;
            o_distinct_count  <= w_count_ext[DCOUNT_W-1:0];
            o_running_sum     <= r_sum;
            o_running_product <= r_prod;
        end
    end

endmodule

`default_nettype wire

[sim/tb_distinct_sum_mod_product.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_sum_mod_product
// Self-checking bench for the distinct sum / modular product block. Items go
// in with random bursts and gaps while the result side stalls in changing
// patterns. A behavioral copy of the set, sum and product predicts every
// report, which is compared field by field in order of arrival.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                                dup;
    logic                                ovf;
    logic [dsmp_pkg::DCOUNT_W-1:0]       cnt;
    logic signed [dsmp_pkg::SUM_W-1:0]   sum;
    logic signed [dsmp_pkg::PROD_W-1:0]  prod;
} t_report;

class t_set_tracker;
    t_report                           reports[$];
    bit                                seen[int];
    int                                held[$];
    int unsigned                       count;
    logic signed [dsmp_pkg::SUM_W-1:0] sum;
    longint                            product;
    int                                errors;

    function new();
        clear();
        errors = 0;
    endfunction

    function void clear();
        seen.delete();
        held.delete();
        count   = 0;
        sum     = '0;
        product = 1;
    endfunction

    function void note_fail(string what, t_report want, t_report got);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s: expected dup=%0b ovf=%0b cnt=%0d sum=%0d prod=%0d",
                     $realtime, what, want.dup, want.ovf, want.cnt,
                     $signed(want.sum), $signed(want.prod));
            $display("%0t: %s:      got dup=%0b ovf=%0b cnt=%0d sum=%0d prod=%0d",
                     $realtime, what, got.dup, got.ovf, got.cnt,
                     $signed(got.sum), $signed(got.prod));
        end
    endfunction

    // Predict the report of one accepted item and queue it.
    function void add_sample(logic signed [dsmp_pkg::SAMPLE_W-1:0] s, bit r);
        t_report rep;
        longint  m;
        m   = longint'(dsmp_pkg::PROD_MOD);
        rep = '0;
        if (r)
            clear();
        if (seen.exists(int'(s))) begin
            rep.dup = 1'b1;
        end else if (count >= dsmp_pkg::TABLE_DEPTH) begin
            rep.ovf = 1'b1;
        end else begin
            seen[int'(s)] = 1'b1;
            held = {held, int'(s)};
            count++;
            sum     = sum + {{(dsmp_pkg::SUM_W - 32){s[31]}}, s};
            // truncating remainder keeps the sign of the product
            product = (product * longint'(s)) % m;
        end
        rep.cnt  = count[dsmp_pkg::DCOUNT_W-1:0];
        rep.sum  = sum;
        rep.prod = product[dsmp_pkg::PROD_W-1:0];
        reports = {reports, rep};
    endfunction

    function void check_report(t_report got);
        t_report want;
        if (reports.size() == 0) begin
            note_fail("result with no item pending", '0, got);
        end else begin
            want = reports.pop_front();
            if (got.dup !== want.dup || got.ovf !== want.ovf || got.cnt !== want.cnt ||
                got.sum !== want.sum || got.prod !== want.prod)
                note_fail("mismatch", want, got);
        end
    endfunction

    function void check_leftover();
        if (reports.size() != 0) begin
            $display("%0t: %0d items never produced a result", $realtime, reports.size());
            errors += reports.size();
        end
    endfunction
endclass

module tb_distinct_sum_mod_product;
    import dsmp_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_restart;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_was_duplicate;
    logic                       o_set_overflow;
    logic [DCOUNT_W-1:0]        o_distinct_count;
    logic signed [SUM_W-1:0]    o_running_sum;
    logic signed [PROD_W-1:0]   o_running_product;

    t_set_tracker sb;
    int           burst_left;
    int           idle_cycles;
    int           rx_mode;
    int           rx_mode_left;
    int           rx_stall_left;
    bit           rx_rdy;
    t_report      rx_got;

    distinct_sum_mod_product u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_was_duplicate   (o_was_duplicate),
        .o_set_overflow    (o_set_overflow),
        .o_distinct_count  (o_distinct_count),
        .o_running_sum     (o_running_sum),
        .o_running_product (o_running_product)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check every accepted report, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_got.dup  = o_was_duplicate;
            rx_got.ovf  = o_set_overflow;
            rx_got.cnt  = o_distinct_count;
            rx_got.sum  = o_running_sum;
            rx_got.prod = o_running_product;
            sb.check_report(rx_got);
        end
        if (rx_mode_left <= 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 400);
        end
        rx_mode_left--;
        case (rx_mode)
            0: rx_rdy = 1'b1;
            1: rx_rdy = $urandom_range(0, 1);
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    rx_rdy = 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall_left = $urandom_range(1, 40);
                    rx_rdy        = 1'b0;
                end else begin
                    rx_rdy = 1'b1;
                end
            end
        endcase
        i_out_ready <= rx_rdy;
    end

    // Watchdog: end the run when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drop valid, scramble the payload and wait out the requested pause.
    task automatic pause(input int n);
        i_in_valid <= 1'b0;
        i_sample   <= $urandom;
        i_restart  <= $urandom_range(0, 1);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic feed(input logic signed [SAMPLE_W-1:0] s, input bit r);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_restart  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.add_sample(s, r);
        burst_left--;
        if (burst_left <= 0) begin
            pause($urandom_range(1, 10));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Hold off the sender until every pending report is back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.reports.size() != 0);
    endtask

    task automatic pick_sample(output logic signed [SAMPLE_W-1:0] s, output bit r);
        int k;
        k = $urandom_range(0, 99);
        r = 1'b0;
        if (k < 4) begin
            // restart, often with a value that the old set holds
            r = 1'b1;
            s = (sb.held.size() != 0 && k < 2)
                ? sb.held[$urandom_range(0, sb.held.size() - 1)] : $urandom;
        end else if (k < 40 && sb.held.size() != 0) begin
            s = sb.held[$urandom_range(0, sb.held.size() - 1)];
        end else if (k < 48) begin
            case ($urandom_range(0, 6))
                0: s = 32'sh7FFF_FFFF;
                1: s = 32'sh8000_0000;
                2: s = 32'sh8000_0001;
                3: s = 32'sh7FFF_FFFE;
                4: s = -32'sd1;
                5: s = 32'sd1;
                default: s = 32'sd0;
            endcase
        end else if (k < 56) begin
            s = $urandom_range(1, 16);
            if ($urandom_range(0, 1))
                s = -s;
        end else begin
            s = $urandom;
        end
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] s;
        bit                         r;
        sb            = new();
        burst_left    = $urandom_range(1, 24);
        idle_cycles   = 0;
        rx_mode       = 0;
        rx_mode_left  = 0;
        rx_stall_left = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_restart   <= 1'b0;
        i_out_ready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, duplicates, zero product, restart over a held value
        feed(32'sh7FFF_FFFF, 1'b0);
        feed(32'sh8000_0000, 1'b0);
        feed(-32'sd1, 1'b0);
        feed(32'sd1, 1'b0);
        feed(32'sh7FFF_FFFF, 1'b0);
        feed(32'sh8000_0000, 1'b0);
        feed(32'sd0, 1'b0);
        feed(32'sd2, 1'b0);
        feed(32'sd0, 1'b0);
        feed(-32'sd1, 1'b1);
        feed(-32'sd1, 1'b0);
        feed(-32'sd2, 1'b0);
        feed(32'sd3, 1'b0);
        feed(32'sh5555_5555, 1'b0);
        feed(32'shAAAA_AAAA, 1'b0);
        feed(32'sd1000000006, 1'b0);
        feed(32'sd1000000007, 1'b0);
        feed(-32'sd1000000007, 1'b1);
        feed(32'sh8000_0000, 1'b1);
        feed(32'sh7FFF_FFFF, 1'b0);
        drain();

        for (int i = 0; i < 750; i++) begin
            pick_sample(s, r);
            feed(s, r);
            if (i == 375)
                drain();
        end
        drain();

        // fill the table with the most negative values, then push past full
        for (int k = 0; k < TABLE_DEPTH; k++)
            feed(32'sh8000_0000 + k, k == 0);
        for (int j = 0; j < 6; j++) begin
            feed($urandom_range(0, 32'h3FFF_FFFF), 1'b0);
            feed(32'sh8000_0000 + $urandom_range(0, TABLE_DEPTH - 1), 1'b0);
        end
        feed(32'sh7FFF_FFFF, 1'b0);
        feed(32'sh8000_0000 + TABLE_DEPTH - 1, 1'b0);
        feed(32'sh8000_0000, 1'b1);
        for (int i = 0; i < 10; i++) begin
            pick_sample(s, r);
            feed(s, r);
        end

        drain();
        repeat (50) @(posedge i_clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/dsmp_pkg.sv
design/dsmp_cell.sv
design/dsmp_row.sv
design/dsmp_modmul.sv
design/distinct_sum_mod_product.sv
sim/tb_distinct_sum_mod_product.sv
